// File: rtl/mp2_pkg.sv
// Shared constants, codes and controller/datapath interface types for the max pooling block.
package mp2_pkg;

  // Largest matrix side; the position counters are sized for it.
  localparam int MAX_SIZE = 64;
  localparam int CNT_W = 6;

  // Defaults for the top-level parameters.
  localparam int MAX_WINDOW_DEF = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register widths and port widths.
  localparam int CFG_W = 7;
  localparam int WIN_W = 4;
  localparam int IDX_W = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;
  localparam logic [IDX_W-1:0] REG_STRIDE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic last_rd;
    logic cfg_busy;
    logic out_busy;
  } dp_sts_t;

endpackage

// File: rtl/mp2_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mp2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/mp2_div.sv
// Restoring divider, one quotient bit per cycle, for the last pooled index.
module mp2_div #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

// File: rtl/mp2_datapath.sv
// Datapath: configuration, position counters, row store, window scan and result register.
module mp2_datapath #(
  parameter int MAX_WINDOW = mp2_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mp2_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  logic                           cfg_wr,
  input  logic [mp2_pkg::IDX_W-1:0]      cfg_index,
  input  logic [mp2_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_pooled_value,
  output logic [mp2_pkg::CNT_W-1:0]      out_row,
  output logic [mp2_pkg::CNT_W-1:0]      out_col,
  output logic                           out_frame_last,
  input  mp2_pkg::ctrl_cmd_t             cmd,
  output mp2_pkg::dp_sts_t               sts
);

  localparam int CW = mp2_pkg::CNT_W;
  localparam int GW = mp2_pkg::CFG_W;
  localparam int WW = mp2_pkg::WIN_W;
  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEPTH = MAX_WINDOW * mp2_pkg::MAX_SIZE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW = $clog2(2 * MAX_WINDOW + 2);

  function automatic logic [CW-1:0] phase_next(input logic [CW-1:0] p, input logic [GW-1:0] s);
    logic [GW-1:0] q;
    q = GW'(p) + GW'(1);
    if (q >= s) begin
      q = '0;
    end
    return q[CW-1:0];
  endfunction

  // Configuration registers.
  logic [GW-1:0] matrix_size_r;
  logic [WW-1:0] window_size_r;
  logic [GW-1:0] stride_r;
  logic          cfg_pend_r;

  // Position counters.
  logic [CW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [CW-1:0] row_phase_r, row_phase_nxt;
  logic [CW-1:0] col_phase_r, col_phase_nxt;
  logic [CW-1:0] pooled_row_r, pooled_row_nxt;
  logic [CW-1:0] pooled_col_r, pooled_col_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  // Scan state.
  logic [SW-1:0] rslot_r;
  logic [CW-1:0] c0_r;
  logic [WW-1:0] si_r;
  logic [WW-1:0] sj_r;
  logic          rd_pend_r;
  logic          rd_first_r;
  logic signed [SAMPLE_BITS-1:0] best_r;
  logic [CW-1:0] meta_row_r;
  logic [CW-1:0] meta_col_r;
  logic          meta_last_r;

  // Result register.
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic [CW-1:0]                 out_row_r;
  logic [CW-1:0]                 out_col_r;
  logic                          out_last_r;

  logic [GW-1:0] n_eff;
  logic [WW-1:0] f_eff;
  logic [GW-1:0] s_eff;
  logic [GW-1:0] in_row_p1;
  logic [GW-1:0] in_col_p1;
  logic          fits;
  logic          row_ready;
  logic          col_ready;
  logic          hit;
  logic          row_end;
  logic          frame_end;
  logic          div_busy;
  logic [GW-1:0] last_q;
  logic [GW-1:0] dividend;
  logic          is_last;
  logic [TW-1:0] tsum;
  logic [TW-1:0] top;
  logic [CW-1:0] scan_col;
  logic          row_wrap;
  logic signed [SAMPLE_BITS-1:0] rd_data;

  // Effective configuration after clamping.
  always_comb begin
    if (matrix_size_r == '0) begin
      n_eff = GW'(1);
    end else if (matrix_size_r > GW'(mp2_pkg::MAX_SIZE)) begin
      n_eff = GW'(mp2_pkg::MAX_SIZE);
    end else begin
      n_eff = matrix_size_r;
    end
    if (window_size_r == '0) begin
      f_eff = WW'(1);
    end else if ((WW + 6)'(window_size_r) > (WW + 6)'(MAX_WINDOW)) begin
      f_eff = WW'(MAX_WINDOW);
    end else begin
      f_eff = window_size_r;
    end
    s_eff = (stride_r == '0) ? GW'(1) : stride_r;
  end

  assign in_row_p1 = GW'(in_row_r) + GW'(1);
  assign in_col_p1 = GW'(in_col_r) + GW'(1);
  assign fits = GW'(f_eff) <= n_eff;
  assign row_ready = in_row_p1 >= GW'(f_eff);
  assign col_ready = in_col_p1 >= GW'(f_eff);
  assign hit = fits && row_ready && col_ready && (row_phase_r == '0) && (col_phase_r == '0);
  assign row_end = in_col_p1 >= n_eff;
  assign frame_end = in_row_p1 >= n_eff;

  // Configuration writes; the last pooled index is recomputed after each one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= GW'(8);
      window_size_r <= WW'(2);
      stride_r <= GW'(2);
      cfg_pend_r <= 1'b1;
    end else begin
      cfg_pend_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          mp2_pkg::REG_MATRIX_SIZE: matrix_size_r <= cfg_data;
          mp2_pkg::REG_WINDOW_SIZE: window_size_r <= cfg_data[WW-1:0];
          mp2_pkg::REG_STRIDE:      stride_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign dividend = fits ? (n_eff - GW'(f_eff)) : '0;

  mp2_div #(
    .W(GW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_pend_r),
    .dividend (dividend),
    .divisor  (s_eff),
    .busy     (div_busy),
    .quotient (last_q)
  );

  assign is_last = (GW'(pooled_row_r) == last_q) && (GW'(pooled_col_r) == last_q);

  // Counter update on each accepted sample.
  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    row_phase_nxt = row_phase_r;
    col_phase_nxt = col_phase_r;
    pooled_row_nxt = pooled_row_r;
    pooled_col_nxt = pooled_col_r;
    slot_nxt = slot_r;
    if (cmd.accept) begin
      if (hit) begin
        pooled_col_nxt = pooled_col_r + CW'(1);
      end
      if (!row_end) begin
        if (col_ready) begin
          col_phase_nxt = phase_next(col_phase_r, s_eff);
        end
        in_col_nxt = in_col_r + CW'(1);
      end else begin
        if (fits && row_ready && (row_phase_r == '0)) begin
          pooled_row_nxt = pooled_row_r + CW'(1);
        end
        pooled_col_nxt = '0;
        col_phase_nxt = '0;
        in_col_nxt = '0;
        if (frame_end) begin
          in_row_nxt = '0;
          row_phase_nxt = '0;
          pooled_row_nxt = '0;
          slot_nxt = '0;
        end else begin
          if (row_ready) begin
            row_phase_nxt = phase_next(row_phase_r, s_eff);
          end
          in_row_nxt = in_row_r + CW'(1);
          slot_nxt = (slot_r == SW'(MAX_WINDOW - 1)) ? '0 : slot_r + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
      row_phase_r <= '0;
      col_phase_r <= '0;
      pooled_row_r <= '0;
      pooled_col_r <= '0;
      slot_r <= '0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      row_phase_r <= row_phase_nxt;
      col_phase_r <= col_phase_nxt;
      pooled_row_r <= pooled_row_nxt;
      pooled_col_r <= pooled_col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Store slot of the window's top row, modulo the number of stored rows.
  assign tsum = TW'(slot_r) + TW'(MAX_WINDOW) + TW'(1) - TW'(f_eff);
  assign top = (tsum >= TW'(MAX_WINDOW)) ? tsum - TW'(MAX_WINDOW) : tsum;

  assign scan_col = c0_r + CW'(sj_r);
  assign row_wrap = (sj_r == f_eff - WW'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rslot_r <= SW'(top);
      c0_r <= CW'(in_col_p1 - GW'(f_eff));
      si_r <= '0;
      sj_r <= '0;
      meta_row_r <= pooled_row_r;
      meta_col_r <= pooled_col_r;
      meta_last_r <= is_last;
    end else if (cmd.scan_rd) begin
      if (row_wrap) begin
        sj_r <= '0;
        si_r <= si_r + WW'(1);
        rslot_r <= (rslot_r == SW'(MAX_WINDOW - 1)) ? '0 : rslot_r + SW'(1);
      end else begin
        sj_r <= sj_r + WW'(1);
      end
    end
  end

  mp2_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (AW'({slot_r, in_col_r})),
    .wdata (in_sample),
    .re    (cmd.scan_rd),
    .raddr (AW'({rslot_r, scan_col})),
    .rdata (rd_data)
  );

  // Running maximum over the returning read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= cmd.scan_rd && (si_r == '0) && (sj_r == '0);
    if (rd_pend_r) begin
      if (rd_first_r || (rd_data > best_r)) begin
        best_r <= rd_data;
      end
    end
  end

  // Result register: one result waits here while the next sample comes in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r <= best_r;
      out_row_r <= meta_row_r;
      out_col_r <= meta_col_r;
      out_last_r <= meta_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pooled_value = out_value_r;
  assign out_row = out_row_r;
  assign out_col = out_col_r;
  assign out_frame_last = out_last_r;

  assign sts.hit = hit;
  assign sts.last_rd = (si_r == f_eff - WW'(1)) && row_wrap;
  assign sts.cfg_busy = cfg_pend_r || div_busy;
  assign sts.out_busy = out_valid_r && !out_ready;

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten");

  // The last window read has come back before the result is loaded.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !rd_pend_r && !cmd.scan_rd)
    else $error("result loaded with a read in flight");

  // No sample is taken while the last pooled index is being recomputed.
  a_cfg_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cfg_pend_r && !div_busy)
    else $error("sample accepted during divide");

endmodule

// File: rtl/mp2_ctrl.sv
// Controller: sequences sample transfer, window scan and result hand-off.
module mp2_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mp2_pkg::dp_sts_t   sts,
  output mp2_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !sts.cfg_busy;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (sts.hit) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.last_rd) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/max_pool_2d_strided.sv
// Top level of the strided 2-D max pooling block.
//
// Samples of a square matrix enter in raster order on the in_ channel, one per
// transfer. The cfg_ channel writes matrix_size (index 0), window_size (index 1)
// and stride (index 2); write only between items. After each configuration
// write, and after reset, the index of the last pooled result is recomputed,
// and in_ready stays low for that time. A sample that completes no window
// leaves in_ready high. A sample that completes a window starts a scan of the
// window from the row store, one read per cycle on its single read port, and
// in_ready stays low until the result is loaded. The result sits in an output
// register, so the next sample is taken while it waits; only a second completed
// window waits for out_ready.
// Each result carries the window maximum, its pooled row and column, and
// out_frame_last on the final result of a frame.
// Reset restores matrix_size 8, window_size 2, stride 2 and clears all position
// counters; the row store is not cleared and holds stale samples.
module max_pool_2d_strided #(
  parameter int MAX_WINDOW = mp2_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mp2_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_pooled_value,
  output logic [mp2_pkg::CNT_W-1:0]     out_row,
  output logic [mp2_pkg::CNT_W-1:0]     out_col,
  output logic                          out_frame_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mp2_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mp2_pkg::CFG_W-1:0]     cfg_data
);

  mp2_pkg::ctrl_cmd_t cmd;
  mp2_pkg::dp_sts_t   sts;

  // Configuration transfers are always taken; they restart the divider.
  assign cfg_ready = 1'b1;

  mp2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mp2_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_sample        (in_sample),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_frame_last   (out_frame_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// File: tb/sv/max_pool_2d_strided_tb.sv
// Self-checking testbench for the strided 2-D max pooling block.
`timescale 1ns / 1ps

module max_pool_2d_strided_tb;

  // The fourth register index decodes to nothing; writes to it must be ignored.
  localparam logic [mp2_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int SMP_W = mp2_pkg::SAMPLE_BITS_DEF;
  localparam int CNT_W = mp2_pkg::CNT_W;
  localparam int STORE_DEPTH = mp2_pkg::MAX_WINDOW_DEF * mp2_pkg::MAX_SIZE;

  // The wait covers the longest scan, an 8x8 window, with a margin. Waiting this
  // long after the last expected result lets a scan that ends in nothing finish.
  localparam int SETTLE_CYCLES = mp2_pkg::MAX_WINDOW_DEF * mp2_pkg::MAX_WINDOW_DEF + 16;

  localparam int RANDOM_ITEMS = 750;
  // The last stretch of the random part runs with no idling on either side.
  localparam int QUIET_ITEMS = 100;

  localparam int RUN_LIMIT_NS = 10_000_000;

  // One pooled result as it leaves the block.
  typedef struct packed {
    logic signed [SMP_W-1:0] value;
    logic [CNT_W-1:0]        row;
    logic [CNT_W-1:0]        col;
    logic                    last;
  } pooled_t;

  // How a directed sample is checked: against the predictor, against nothing,
  // or against a result typed into the table.
  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_NONE,
    CHECK_GIVEN
  } check_t;

  // One row of the directed table: either a register write or a sample.
  typedef struct {
    bit                           is_cfg;
    logic [mp2_pkg::IDX_W-1:0]    idx;
    logic signed [SMP_W-1:0]      value;
    check_t                       check;
    logic signed [SMP_W-1:0]      want_value;
    bit                           want_last;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [SMP_W-1:0]      in_sample = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [SMP_W-1:0]      out_pooled_value;
  logic [CNT_W-1:0]             out_row;
  logic [CNT_W-1:0]             out_col;
  logic                         out_frame_last;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [mp2_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [mp2_pkg::CFG_W-1:0]    cfg_data = '0;

  max_pool_2d_strided u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Results the predictor has worked out and the block still owes, oldest first.
  pooled_t pooled_due[$];
  stim_row_t directed[$];
  int mismatch_count = 0;

  // Idling controls. Each phase of the random part turns idling on or off per
  // side, so that long stretches with no gaps also occur.
  bit send_idling = 1'b1;
  bit recv_idling = 1'b1;
  bit quiet = 1'b0;
  int rand_items = 0;
  int stall_left = 0;

  // Predictor state: the configuration as written, a copy of the row store, the
  // position of the next sample, the stride offsets and the next pooled position.
  int unsigned side_reg = 8;
  int unsigned win_reg = 2;
  int unsigned stride_reg = 2;
  logic signed [SMP_W-1:0] win_store[STORE_DEPTH];
  int unsigned pos_row = 0, pos_col = 0;
  int unsigned row_step = 0, col_step = 0;
  int unsigned pool_row = 0, pool_col = 0;

  // Zero means one, and anything above the limit means the limit.
  function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // The store holds the latest MAX_WINDOW rows, one slot of MAX_SIZE per row.
  function automatic int unsigned slot(input int unsigned r, input int unsigned c);
    return ((r % mp2_pkg::MAX_WINDOW_DEF) * mp2_pkg::MAX_SIZE + c) % STORE_DEPTH;
  endfunction

  // Advance an offset on the stride grid. It wraps at the stride and is kept to
  // the counter width, which matters only for strides above the counter range.
  function automatic int unsigned step_next(input int unsigned p, input int unsigned s);
    int unsigned q;
    q = p + 1;
    if (q >= s) begin
      q = 0;
    end
    return q & ((1 << CNT_W) - 1);
  endfunction

  // Work out what one accepted sample causes. Returns 1 with the result filled
  // in when the sample is the bottom-right corner of a window on the grid.
  function automatic bit pool_step(input logic signed [SMP_W-1:0] smp, output pooled_t res);
    int unsigned n, f, s, r0, c0, last_idx, i, j;
    bit fits, row_rdy, col_rdy, hit;
    logic signed [SMP_W-1:0] best, v;
    n = clamp(side_reg, mp2_pkg::MAX_SIZE);
    f = clamp(win_reg, mp2_pkg::MAX_WINDOW_DEF);
    s = clamp(stride_reg, 32'hFFFF_FFFF);
    win_store[slot(pos_row, pos_col)] = smp;
    fits = f <= n;
    row_rdy = pos_row + 1 >= f;
    col_rdy = pos_col + 1 >= f;
    hit = fits && row_rdy && col_rdy && row_step == 0 && col_step == 0;
    res = '0;
    if (hit) begin
      r0 = pos_row + 1 - f;
      c0 = pos_col + 1 - f;
      last_idx = (n - f) / s;
      best = win_store[slot(r0, c0)];
      for (i = 0; i < f; i++) begin
        for (j = 0; j < f; j++) begin
          v = win_store[slot(r0 + i, c0 + j)];
          if (v > best) begin
            best = v;
          end
        end
      end
      res.value = best;
      res.row = CNT_W'(pool_row);
      res.col = CNT_W'(pool_col);
      res.last = (pool_row == last_idx) && (pool_col == last_idx);
      pool_col = (pool_col + 1) & ((1 << CNT_W) - 1);
    end
    if (pos_col + 1 < n) begin
      if (col_rdy) begin
        col_step = step_next(col_step, s);
      end
      pos_col = (pos_col + 1) & ((1 << CNT_W) - 1);
    end else begin
      // End of an input row: the pooled row advances only if this row held windows.
      if (fits && row_rdy && row_step == 0) begin
        pool_row = (pool_row + 1) & ((1 << CNT_W) - 1);
      end
      pool_col = 0;
      col_step = 0;
      pos_col = 0;
      if (pos_row + 1 >= n) begin
        // End of the frame: every counter returns to zero, the store is kept.
        pos_row = 0;
        row_step = 0;
        pool_row = 0;
      end else begin
        if (row_rdy) begin
          row_step = step_next(row_step, s);
        end
        pos_row = (pos_row + 1) & ((1 << CNT_W) - 1);
      end
    end
    return hit;
  endfunction

  function automatic void add_cfg(input logic [mp2_pkg::IDX_W-1:0] idx,
                                  input logic [mp2_pkg::CFG_W-1:0] data);
    stim_row_t r;
    r = '{1'b1, idx, SMP_W'(data), CHECK_NONE, '0, 1'b0};
    directed.push_back(r);
  endfunction

  // Every typed result in the table sits at pooled position (0, 0).
  function automatic void add_sample(input logic signed [SMP_W-1:0] v,
                                     input check_t how = CHECK_MODEL,
                                     input logic signed [SMP_W-1:0] want = '0,
                                     input bit last = 1'b0);
    stim_row_t r;
    r = '{1'b0, '0, v, how, want, last};
    directed.push_back(r);
  endfunction

  // Mostly full-range values, with the extremes and tight clusters mixed in so
  // that windows often hold ties and near ties.
  function automatic logic signed [SMP_W-1:0] any_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SMP_W'($urandom_range(0, 15)) - 16'sd8;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the transfer, with an optional idle
  // burst first. The prediction is made at the edge of the transfer.
  task automatic put_sample(input logic signed [SMP_W-1:0] smp, output bit got,
                            output pooled_t res);
    if (send_idling && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    got = pool_step(smp, res);
  endtask

  // Write one register. Valid is left high so that a following write in the
  // same batch does not lower and raise it within one time step.
  task automatic write_reg(input logic [mp2_pkg::IDX_W-1:0] idx,
                           input logic [mp2_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mp2_pkg::REG_MATRIX_SIZE: side_reg = data;
      mp2_pkg::REG_WINDOW_SIZE: win_reg = data & 4'hF;
      mp2_pkg::REG_STRIDE:      stride_reg = data;
      default: ;
    endcase
  endtask

  // Stop offering samples, let every owed result arrive, then give a scan that
  // produces nothing time to finish before the configuration is touched.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pooled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random samples, either a fixed count or up to the end of the current frame.
  task automatic feed(input int unsigned count, input bit to_frame_end);
    int unsigned k;
    bit got;
    pooled_t res;
    k = 0;
    while (to_frame_end ? (k == 0 || pos_row != 0 || pos_col != 0) : (k < count)) begin
      put_sample(any_sample(), got, res);
      if (got) begin
        pooled_due.push_back(res);
      end
      k++;
      rand_items++;
      quiet = rand_items + QUIET_ITEMS >= RANDOM_ITEMS;
    end
  endtask

  // The receiver stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (recv_idling && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result transfer is compared field by field with the oldest owed result.
  always @(posedge clk) begin : check_results
    pooled_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pooled_due.size() == 0) begin
        $error("result with none owed: value %0d row %0d col %0d last %0b",
               out_pooled_value, out_row, out_col, out_frame_last);
        mismatch_count++;
      end else begin
        want = pooled_due.pop_front();
        if (out_pooled_value !== want.value) begin
          $error("pooled_value: expected %0d, got %0d", $signed(want.value),
                 out_pooled_value);
          mismatch_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          mismatch_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          mismatch_count++;
        end
        if (out_frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, out_frame_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t r;
    pooled_t res;
    bit got, writing, big, mid, first_phase, wr_side, wr_win, wr_stride;
    int unsigned side_now, side_new, win_new, stride_new, win_hi, big_left, side;

    // Directed part. First the default window and stride on a side of two, with
    // the largest sample in a window of the smallest ones, then a window made only
    // of the most negative value, which shows that the running maximum starts low enough.
    add_cfg(mp2_pkg::REG_MATRIX_SIZE, 7'd2);
    add_sample(16'sh7FFF, CHECK_NONE);
    add_sample(16'sh8000, CHECK_NONE);
    add_sample(16'sh8000, CHECK_NONE);
    add_sample(16'sh8000, CHECK_GIVEN, 16'sh7FFF, 1'b1);
    add_sample(16'sh8000, CHECK_NONE);
    add_sample(16'sh8000, CHECK_NONE);
    add_sample(16'sh8000, CHECK_NONE);
    add_sample(16'sh8000, CHECK_GIVEN, 16'sh8000, 1'b1);
    // A zero side and a zero window both act as one, so each sample is a whole
    // frame and its own maximum. The write to the unused index changes nothing.
    add_cfg(mp2_pkg::REG_MATRIX_SIZE, 7'd0);
    add_cfg(mp2_pkg::REG_WINDOW_SIZE, 7'd0);
    add_cfg(REG_UNUSED, 7'h7F);
    add_sample(16'sh5555, CHECK_GIVEN, 16'sh5555, 1'b1);
    add_sample(16'shAAAA, CHECK_GIVEN, 16'shAAAA, 1'b1);
    // An oversized window is cut to eight and then no longer fits the matrix.
    add_cfg(mp2_pkg::REG_WINDOW_SIZE, 7'd15);
    add_sample(16'sh0000, CHECK_NONE);
    // Overlapping windows: a zero stride acts as one.
    add_cfg(mp2_pkg::REG_MATRIX_SIZE, 7'd3);
    add_cfg(mp2_pkg::REG_WINDOW_SIZE, 7'd2);
    add_cfg(mp2_pkg::REG_STRIDE, 7'd0);
    add_sample(16'sd5);
    add_sample(-16'sd7);
    add_sample(16'sd100);
    add_sample(16'sd3);
    add_sample(-16'sd1);
    add_sample(16'sd0);
    add_sample(16'sd200);
    add_sample(-16'sd300);
    add_sample(16'sd1);
    // The largest stride leaves only the window at the origin.
    add_cfg(mp2_pkg::REG_MATRIX_SIZE, 7'd2);
    add_cfg(mp2_pkg::REG_WINDOW_SIZE, 7'd1);
    add_cfg(mp2_pkg::REG_STRIDE, 7'd127);
    add_sample(16'shFFFF, CHECK_GIVEN, 16'shFFFF, 1'b1);
    add_sample(16'sh7FFF, CHECK_NONE);
    add_sample(16'sh8000, CHECK_NONE);
    add_sample(16'sd12, CHECK_NONE);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table. A run of register rows forms one batch, written once the
    // block is idle; the first sample after it closes the batch.
    writing = 1'b0;
    foreach (directed[k]) begin
      r = directed[k];
      if (r.is_cfg) begin
        if (!writing) begin
          wait_idle();
          writing = 1'b1;
        end
        write_reg(r.idx, mp2_pkg::CFG_W'(r.value));
      end else begin
        if (writing) begin
          cfg_valid <= 1'b0;
          writing = 1'b0;
        end
        put_sample(r.value, got, res);
        if (r.check == CHECK_MODEL && got) begin
          pooled_due.push_back(res);
        end else if (r.check == CHECK_GIVEN) begin
          pooled_due.push_back('{r.want_value, '0, '0, r.want_last});
        end
      end
    end

    // Random part, in phases. Each phase waits for the block to go idle, writes
    // some registers and sends a run of samples. The first phase, and at most one
    // more, uses a side of 40 or more; such a phase stops partway
    // through its frame so that it stays short.
    big_left = 2;
    first_phase = 1'b1;
    while (rand_items < RANDOM_ITEMS) begin
      mid = pos_row != 0 || pos_col != 0;
      big = !mid && big_left > 0 && (first_phase || $urandom_range(0, 19) == 0);
      if (big) begin
        big_left--;
      end
      first_phase = 1'b0;
      wait_idle();

      // Within a frame the side may only shrink. Earlier rows of the frame then
      // cover every column a later window reads, so no never-written store entry
      // is ever read.
      side_now = clamp(side_reg, mp2_pkg::MAX_SIZE);
      if (big) begin
        side_new = $urandom_range(0, 1) ? 127 : $urandom_range(40, 126);
      end else if (mid) begin
        side_new = $urandom_range(0, side_now);
      end else if ($urandom_range(0, 4) == 0) begin
        side_new = $urandom_range(13, 20);
      end else begin
        side_new = $urandom_range(0, 12);
      end
      win_hi = clamp(side_new, mp2_pkg::MAX_SIZE);
      win_hi = (win_hi < mp2_pkg::MAX_WINDOW_DEF) ? win_hi : mp2_pkg::MAX_WINDOW_DEF;
      win_new = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, win_hi);
      case ($urandom_range(0, 9))
        0: stride_new = 0;
        1: stride_new = 127;
        2: stride_new = $urandom_range(0, 127);
        default: stride_new = $urandom_range(1, 4);
      endcase

      wr_side = big || $urandom_range(0, 3) != 0;
      wr_win = $urandom_range(0, 3) != 0;
      wr_stride = $urandom_range(0, 3) != 0;
      if (!wr_side && !wr_stride) begin
        wr_win = 1'b1;
      end
      if (wr_side) begin
        write_reg(mp2_pkg::REG_MATRIX_SIZE, mp2_pkg::CFG_W'(side_new));
      end
      if (wr_win) begin
        write_reg(mp2_pkg::REG_WINDOW_SIZE, mp2_pkg::CFG_W'(win_new));
      end
      if (wr_stride) begin
        write_reg(mp2_pkg::REG_STRIDE, mp2_pkg::CFG_W'(stride_new));
      end
      cfg_valid <= 1'b0;

      send_idling = $urandom_range(0, 3) != 0;
      recv_idling = $urandom_range(0, 3) != 0;
      side = clamp(side_reg, mp2_pkg::MAX_SIZE);
      if (big) begin
        feed(side * $urandom_range(1, 5) + $urandom_range(0, side - 1), 1'b0);
      end else if (side <= 20 && $urandom_range(0, 1) == 0) begin
        feed(0, 1'b1);
        if (side <= 8 && $urandom_range(0, 1) == 0) begin
          feed(0, 1'b1);
        end
      end else begin
        feed($urandom_range(1, 60), 1'b0);
      end
    end

    // Drain: every owed result must arrive, then a quiet spell catches extras.
    in_valid <= 1'b0;
    while (pooled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // A hung handshake or a missing result ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
